>>> hdl/unst_pkg.sv
// Shared types, codes and the name-forming function of the name slot table.
`default_nettype none
package unst_pkg;

   localparam int NAME_BYTES = 9;
   localparam int NAME_W     = 72;
   localparam int SLOT_W     = 4;

   localparam logic [1:0] ACT_QUERY  = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_IN_USE    = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] name_head;
      logic [7:0]  name_tail;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic match;
      logic free;
   } cmp_flags_type;

   typedef struct packed {
      logic              en;
      logic [NAME_W-1:0] data;
   } wr_cmd_type;

   // Zero every byte from the first zero byte on, and every byte past NAME_BYTES.
   function automatic logic [NAME_W-1:0] form_name(input logic [63:0] head,
                                                   input logic [7:0]  tail);
      logic [NAME_W-1:0] raw;
      logic [NAME_W-1:0] nm;
      logic              ended;
      raw   = {tail, head};
      nm    = '0;
      ended = 1'b0;
      for (int b = 0; b < 9; b++) begin
         if (b >= NAME_BYTES || raw[8*b +: 8] == 8'd0) begin
            ended = 1'b1;
         end
         nm[8*b +: 8] = ended ? 8'd0 : raw[8*b +: 8];
      end
      return nm;
   endfunction

endpackage
`default_nettype wire

>>> hdl/unst_store.sv
// Name storage: one read port with registered data, one write port, per-slot valid bits.
`default_nettype none
module unst_store #(
   parameter int SLOTS = 10,
   parameter int IDX_W = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [IDX_W-1:0]            rd_addr,
   output logic [unst_pkg::NAME_W-1:0]      rd_data,
   input  wire unst_pkg::wr_cmd_type        wr_cmd,
   input  wire logic [IDX_W-1:0]            wr_addr
);
   import unst_pkg::*;

   logic [NAME_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]  valid_ff;
   logic [NAME_W-1:0] rd_word_ff;
   logic              rd_ok_ff;

   always_ff @(posedge clock) begin
      if (wr_cmd.en) begin
         mem[wr_addr] <= wr_cmd.data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_cmd.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= valid_ff[rd_addr];
         end
      end
   end

   // A slot never written reads as free.
   assign rd_data = rd_ok_ff ? rd_word_ff : '0;

endmodule
`default_nettype wire

>>> hdl/unst_cmp.sv
// Shared compare unit: tests one stored slot against the request name.
`default_nettype none
module unst_cmp (
   input  wire logic [unst_pkg::NAME_W-1:0] slot_word,
   input  wire logic [unst_pkg::NAME_W-1:0] name,
   output unst_pkg::cmp_flags_type          flags
);
   import unst_pkg::*;

   always_comb begin
      flags.match = (slot_word == name);
      flags.free  = (slot_word == '0);
   end

endmodule
`default_nettype wire

>>> hdl/unique_name_slot_table_top.sv
// Top level of the name slot table: scan sequencer, store and compare unit.
// A table of SLOTS names of up to nine bytes; query, add and remove each give
// one response beat. A request with a nonempty name is scanned one slot per
// cycle through the single read port of the store and a shared comparator:
// accept, one read per slot, a trailing compare, decide and write, then load
// the response register, which waits while an earlier response is not yet
// taken. An empty name skips the scan. Only one request is in work at a time;
// the next is taken while a response still waits. After reset every slot reads
// as free at once.
`default_nettype none
module unique_name_slot_table_top #(
   parameter int SLOTS = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire unst_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output unst_pkg::rsp_type      rsp_data
);
   import unst_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_HOLD
   } state_type;

   state_type         state_ff;
   logic [1:0]        action_ff;
   logic [NAME_W-1:0] name_ff;
   logic [CNT_W-1:0]  issue_cnt_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   rsp_type           res_ff;
   rsp_type           res_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [NAME_W-1:0] req_name;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [NAME_W-1:0] rd_data;
   wr_cmd_type        wr_cmd;
   logic [IDX_W-1:0]  wr_addr;
   cmp_flags_type     flags;
   logic              issue_more;
   logic              rsp_load;

   assign req_name   = form_name(req_data.name_head, req_data.name_tail);
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign issue_more = (issue_cnt_ff < CNT_W'(SLOTS));
   assign rd_en      = (state_ff == S_SCAN) && issue_more;
   assign rd_addr    = issue_cnt_ff[IDX_W-1:0];
   assign rsp_load   = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_ready);

   unst_store #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_cmd  (wr_cmd),
      .wr_addr (wr_addr)
   );

   unst_cmp u_cmp (
      .slot_word (rd_data),
      .name      (name_ff),
      .flags     (flags)
   );

   // Decide the outcome once every slot has been compared.
   always_comb begin
      res_in      = '{status: STATUS_OK, slot: '0};
      wr_cmd.en   = 1'b0;
      wr_cmd.data = name_ff;
      wr_addr     = free_idx_ff;
      if (state_ff == S_DECIDE) begin
         case (action_ff)
            ACT_ADD: begin
               if (hit_ff) begin
                  res_in = '{status: STATUS_IN_USE, slot: SLOT_W'(hit_idx_ff)};
               end else if (free_ff) begin
                  wr_cmd.en = 1'b1;
                  res_in    = '{status: STATUS_OK, slot: SLOT_W'(free_idx_ff)};
               end else begin
                  res_in = '{status: STATUS_FULL, slot: '0};
               end
            end
            ACT_REMOVE: begin
               if (hit_ff) begin
                  wr_cmd.en   = 1'b1;
                  wr_cmd.data = '0;
                  wr_addr     = hit_idx_ff;
                  res_in      = '{status: STATUS_OK, slot: SLOT_W'(hit_idx_ff)};
               end else begin
                  res_in = '{status: STATUS_NOT_FOUND, slot: '0};
               end
            end
            default: begin
               if (hit_ff) begin
                  res_in = '{status: STATUS_IN_USE, slot: SLOT_W'(hit_idx_ff)};
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  action_ff <= req_data.action;
                  name_ff   <= req_name;
                  if (req_name[7:0] == 8'd0) begin
                     // Empty name: answer without a scan.
                     res_ff.status <= (req_data.action == ACT_REMOVE) ?
                                      STATUS_NOT_FOUND : STATUS_IN_USE;
                     res_ff.slot   <= '0;
                     state_ff      <= S_HOLD;
                  end else begin
                     issue_cnt_ff <= '0;
                     pend_ff      <= 1'b0;
                     hit_ff       <= 1'b0;
                     free_ff      <= 1'b0;
                     state_ff     <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (issue_more) begin
                  issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
               end
               pend_ff     <= issue_more;
               pend_idx_ff <= rd_addr;
               // Keep the first match and the first free slot.
               if (pend_ff) begin
                  if (flags.match && !hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= pend_idx_ff;
                  end
                  if (flags.free && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= pend_idx_ff;
                  end
               end
               // Leave on the trailing compare of the last slot.
               if (!issue_more) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               res_ff   <= res_in;
               state_ff <= S_HOLD;
            end
            S_HOLD: begin
               if (rsp_load) begin
                  rsp_ff   <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> dv/unique_name_slot_table_top_test.sv
// Testbench for the name slot table: directed and random query/add/remove traffic.
`timescale 1ns / 100ps
module unique_name_slot_table_top_test;
   import unst_pkg::*;

   localparam int SLOT_COUNT  = 10;
   localparam int POOL_SIZE   = 16;
   localparam int SETTLE      = 2 * (SLOT_COUNT + 4);
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [71:0] stored_names [SLOT_COUNT];
   logic [71:0] name_pool [POOL_SIZE];
   rsp_type     expected_rsp_q [$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;
   int          rsp_hold_request = 0;
   int          rsp_hold_left = 0;

   unique_name_slot_table_top #(.SLOTS(SLOT_COUNT)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Keep bytes up to the first zero byte; everything after it counts as padding.
   function automatic logic [71:0] trim_name(input logic [63:0] head, input logic [7:0] tail);
      logic [71:0] raw;
      logic [71:0] kept;
      raw  = {tail, head};
      kept = '0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (raw[8*b +: 8] == 8'd0) break;
         kept[8*b +: 8] = raw[8*b +: 8];
      end
      return kept;
   endfunction

   function automatic rsp_type predict_table_op(input req_type item);
      logic [71:0] nm;
      int          hit;
      int          vacant;
      rsp_type     res;
      nm         = trim_name(item.name_head, item.name_tail);
      hit        = -1;
      vacant     = -1;
      res.status = STATUS_OK;
      res.slot   = '0;
      // scan downward so the lowest index wins
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (stored_names[s] == nm) hit = s;
         if (stored_names[s] == '0) vacant = s;
      end
      if (nm[7:0] == 8'd0) begin
         res.status = (item.action == ACT_REMOVE) ? STATUS_NOT_FOUND : STATUS_IN_USE;
      end else if (item.action == ACT_ADD) begin
         if (hit >= 0) begin
            res.status = STATUS_IN_USE;
            res.slot   = hit[SLOT_W-1:0];
         end else if (vacant < 0) begin
            res.status = STATUS_FULL;
         end else begin
            stored_names[vacant] = nm;
            res.slot             = vacant[SLOT_W-1:0];
         end
      end else if (item.action == ACT_REMOVE) begin
         if (hit >= 0) begin
            stored_names[hit] = '0;
            res.slot          = hit[SLOT_W-1:0];
         end else begin
            res.status = STATUS_NOT_FOUND;
         end
      end else if (hit >= 0) begin
         res.status = STATUS_IN_USE;
         res.slot   = hit[SLOT_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [71:0] make_name(input int len);
      logic [71:0] nm;
      nm = '0;
      for (int b = 0; b < len; b++) nm[8*b +: 8] = 8'($urandom_range(255, 1));
      return nm;
   endfunction

   // Fill the bytes past the terminator with garbage when junk is set.
   function automatic req_type build_request(input logic [1:0] act, input logic [71:0] nm,
                                             input bit junk);
      logic [71:0] raw;
      bit          ended;
      req_type     item;
      raw   = nm;
      ended = 1'b0;
      for (int b = 0; b < 9; b++) begin
         if (ended && junk) raw[8*b +: 8] = 8'($urandom_range(255));
         if (nm[8*b +: 8] == 8'd0) ended = 1'b1;
      end
      item.action    = act;
      item.name_head = raw[63:0];
      item.name_tail = raw[71:64];
      return item;
   endfunction

   // Entered and left at a falling edge.
   task automatic offer_request(input req_type item);
      while (!no_idle && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp_q.push_back(predict_table_op(item));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_rsp_q.size() != 0);
   endtask

   task automatic run_table_traffic(input int count);
      req_type    item;
      logic [1:0] act;
      int         pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) act = ACT_ADD;
         else if (pick < 70) act = ACT_REMOVE;
         else if (pick < 95) act = ACT_QUERY;
         else act = ACT_SPARE;
         pick = $urandom_range(99);
         if (pick < 8) begin
            item.action    = act;
            item.name_head = {$urandom, $urandom};
            item.name_tail = 8'($urandom_range(255));
         end else if (pick < 11) begin
            item = build_request(act, '0, 1'($urandom_range(1)));
         end else begin
            item = build_request(act, name_pool[$urandom_range(POOL_SIZE - 1)],
                                 1'($urandom_range(1)));
         end
         offer_request(item);
      end
   endtask

   task automatic test_directed_cases();
      logic [71:0] full_ff;
      logic [71:0] one_byte;
      logic [71:0] eight_byte;
      logic [71:0] absent;
      logic [71:0] fillers [8];
      full_ff    = {9{8'hFF}};
      one_byte   = 72'h01;
      eight_byte = {8'h00, 64'h8080_4020_1008_0402};
      absent     = 72'h7F55;
      for (int b = 0; b < 8; b++) fillers[b] = make_name(b + 1);
      // empty names, with and without garbage after the leading zero
      offer_request(build_request(ACT_QUERY, '0, 1'b1));
      offer_request(build_request(ACT_ADD, '0, 1'b1));
      offer_request(build_request(ACT_REMOVE, '0, 1'b0));
      offer_request(build_request(ACT_QUERY, one_byte, 1'b0));
      offer_request(build_request(ACT_ADD, full_ff, 1'b0));
      offer_request(build_request(ACT_QUERY, full_ff, 1'b0));
      offer_request(build_request(ACT_ADD, full_ff, 1'b0));
      offer_request(build_request(ACT_ADD, one_byte, 1'b1));
      offer_request(build_request(ACT_SPARE, full_ff, 1'b0));
      offer_request(build_request(ACT_REMOVE, full_ff, 1'b0));
      offer_request(build_request(ACT_REMOVE, full_ff, 1'b0));
      offer_request(build_request(ACT_ADD, eight_byte, 1'b0));
      for (int b = 0; b < 8; b++) offer_request(build_request(ACT_ADD, fillers[b], 1'b0));
      // table is full now
      offer_request(build_request(ACT_ADD, absent, 1'b1));
      offer_request(build_request(ACT_QUERY, absent, 1'b0));
      offer_request(build_request(ACT_REMOVE, fillers[3], 1'b1));
      offer_request(build_request(ACT_ADD, absent, 1'b0));
      drain_results();
   endtask

   task automatic test_random_traffic();
      run_table_traffic(550);
      drain_results();
   endtask

   task automatic test_steady_stream();
      no_idle = 1'b1;
      run_table_traffic(220);
      drain_results();
      no_idle = 1'b0;
   endtask

   task automatic test_response_backpressure();
      no_idle          = 1'b1;
      rsp_hold_request = 300;
      run_table_traffic(120);
      drain_results();
      no_idle = 1'b0;
   endtask

   // Response side: random stalls, plus a long hold-off when a test asks for one.
   always @(negedge clock) begin
      if (rsp_hold_request != 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response beat with nothing expected: status %0d slot %0d",
                   rsp_data.status, rsp_data.slot);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_data.slot);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < SLOT_COUNT; s++) stored_names[s] = '0;
      for (int p = 0; p < POOL_SIZE; p++) name_pool[p] = make_name($urandom_range(9, 1));
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_random_traffic();
      test_steady_stream();
      test_response_backpressure();

      // catch any stray beat after the last expected one
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
